/* sv/bdpd_pkg.sv */
`default_nettype none

package bdpd_pkg;

    // field widths fixed by the command and result words
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned POS_W   = 16;
    localparam int unsigned COUNT_W = 7;

    // command codes
    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_POP_FRONT  = 2'd1,
        CMD_POP_BACK   = 2'd2,
        CMD_DELETE_AT  = 2'd3
    } cmd_t;

    // status codes
    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_FULL    = 2'd2,
        ST_IGNORED = 2'd3
    } status_t;

    // what every cell of the row does on one edge
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_PUSH   = 2'd1,
        CELL_REMOVE = 2'd2
    } cell_op_t;

    // broadcast control from the sequencer to the cell row
    typedef struct packed {
        cell_op_t           op;
        logic [POS_W-1:0]   del_idx;
    } cell_ctl_t;

    // command word
    typedef struct packed {
        cmd_t                       command;
        logic signed [VALUE_W-1:0]  value;
        logic signed [POS_W-1:0]    position;
    } in_word_t;

    // result word
    typedef struct packed {
        status_t                    status;
        logic [COUNT_W-1:0]         count;
        logic signed [VALUE_W-1:0]  front_value;
        logic signed [VALUE_W-1:0]  back_value;
    } out_word_t;

endpackage

`default_nettype wire

/* sv/bdpd_cell.sv */
`default_nettype none

module bdpd_cell #(
    parameter int INDEX = 0
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire bdpd_pkg::cell_ctl_t                     ctl,
    input  wire logic signed [bdpd_pkg::VALUE_W-1:0]     left_value,
    input  wire logic                                    left_valid,
    input  wire logic signed [bdpd_pkg::VALUE_W-1:0]     right_value,
    input  wire logic                                    right_valid,
    output logic signed [bdpd_pkg::VALUE_W-1:0]          value,
    output logic                                         valid,
    output logic                                         last
);

    logic signed [bdpd_pkg::VALUE_W-1:0] value_reg;
    logic signed [bdpd_pkg::VALUE_W-1:0] value_next;
    logic                                valid_reg;
    logic                                valid_next;
    logic                                at_or_after;

    // this cell sits at or behind the entry being removed
    assign at_or_after = (bdpd_pkg::POS_W'(INDEX) >= ctl.del_idx);

    // shift toward the back on push, toward the front on remove
    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        case (ctl.op)
            bdpd_pkg::CELL_PUSH:
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            bdpd_pkg::CELL_REMOVE:
            begin
                if (at_or_after)
                begin
                    value_next = right_value;
                    valid_next = right_valid;
                end
            end
            default:
            begin
                value_next = value_reg;
                valid_next = valid_reg;
            end
        endcase
    end

    // entry data, no reset
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    // occupied flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign value = value_reg;
    assign valid = valid_reg;
    assign last  = valid_reg & ~right_valid;

endmodule

`default_nettype wire

/* sv/bdpd_ctrl.sv */
`default_nettype none

module bdpd_ctrl #(
    parameter int DEPTH   = 64,
    parameter int COUNT_W = $clog2(DEPTH + 1)
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire bdpd_pkg::in_word_t    item,
    output bdpd_pkg::cell_ctl_t        ctl,
    output logic [COUNT_W-1:0]         count,
    output bdpd_pkg::status_t          status,
    output logic                       done
);

    logic [COUNT_W-1:0]           count_reg;
    logic [COUNT_W-1:0]           count_next;
    bdpd_pkg::status_t            status_reg;
    bdpd_pkg::status_t            status_next;
    logic                         done_reg;
    logic                         done_next;
    logic [bdpd_pkg::POS_W-1:0]   pos_idx;
    logic                         is_empty;
    logic                         is_full;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == COUNT_W'(DEPTH));

    // zero-based index for delete, position zero acts as the front
    assign pos_idx = (item.position == '0) ? '0
                   : (bdpd_pkg::POS_W'(item.position) - bdpd_pkg::POS_W'(1));

    // command decode
    always_comb
    begin
        ctl.op      = bdpd_pkg::CELL_HOLD;
        ctl.del_idx = '0;
        count_next  = count_reg;
        status_next = status_reg;
        done_next   = start;
        if (start)
        begin
            status_next = bdpd_pkg::ST_DONE;
            case (item.command)
                bdpd_pkg::CMD_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = bdpd_pkg::ST_FULL;
                    end
                    else
                    begin
                        ctl.op     = bdpd_pkg::CELL_PUSH;
                        count_next = count_reg + COUNT_W'(1);
                    end
                end
                bdpd_pkg::CMD_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = bdpd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.op     = bdpd_pkg::CELL_REMOVE;
                        count_next = count_reg - COUNT_W'(1);
                    end
                end
                bdpd_pkg::CMD_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = bdpd_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        ctl.op      = bdpd_pkg::CELL_REMOVE;
                        ctl.del_idx = bdpd_pkg::POS_W'(count_reg - COUNT_W'(1));
                        count_next  = count_reg - COUNT_W'(1);
                    end
                end
                bdpd_pkg::CMD_DELETE_AT:
                begin
                    if (is_empty)
                    begin
                        status_next = bdpd_pkg::ST_EMPTY;
                    end
                    else if (item.position[bdpd_pkg::POS_W-1])
                    begin
                        status_next = bdpd_pkg::ST_IGNORED;
                    end
                    else if (pos_idx >= bdpd_pkg::POS_W'(count_reg))
                    begin
                        status_next = bdpd_pkg::ST_IGNORED;
                    end
                    else
                    begin
                        ctl.op      = bdpd_pkg::CELL_REMOVE;
                        ctl.del_idx = pos_idx;
                        count_next  = count_reg - COUNT_W'(1);
                    end
                end
                default:
                begin
                    status_next = bdpd_pkg::ST_DONE;
                end
            endcase
        end
    end

    // occupancy, status and strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            status_reg <= bdpd_pkg::ST_DONE;
            done_reg   <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            status_reg <= status_next;
            done_reg   <= done_next;
        end
    end

    assign count  = count_reg;
    assign status = status_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

/* sv/bounded_deque_positional_delete_core.sv */
`default_nettype none

// Ordered store of up to DEPTH signed 32-bit words with push front, pop front,
// pop back and delete at a 1-based position. A command is taken on any edge
// with start high; busy stays low, so one command per clock is sustained.
// Every command gives one result word, shown with done for exactly one cycle,
// the cycle right after the command was taken; the receiver must take it then.
// The DEPTH cells update on one edge: all shift one place on a push, those at
// or behind the removed entry on a removal. Front and back words are read from
// the cells, the back one via a DEPTH-wide select on the last occupied cell.
// No clearing pass after reset: only occupied cells are ever shown.
module bounded_deque_positional_delete_core #(
    parameter int DEPTH = 64
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire bdpd_pkg::in_word_t    item,
    output logic                       busy,
    output logic                       done,
    output bdpd_pkg::out_word_t        result
);

    localparam int COUNT_W = $clog2(DEPTH + 1);

    bdpd_pkg::cell_ctl_t                   ctl;
    logic [COUNT_W-1:0]                    count;
    bdpd_pkg::status_t                     status;
    logic signed [bdpd_pkg::VALUE_W-1:0]   cell_value [DEPTH];
    logic [DEPTH-1:0]                      cell_valid;
    logic [DEPTH-1:0]                      cell_last;
    logic signed [bdpd_pkg::VALUE_W-1:0]   back_word;

    // sequencer with the occupancy count
    bdpd_ctrl #(
        .DEPTH   (DEPTH),
        .COUNT_W (COUNT_W)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .ctl    (ctl),
        .count  (count),
        .status (status),
        .done   (done)
    );

    // row of cells, front at index zero
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [bdpd_pkg::VALUE_W-1:0] lv;
        logic signed [bdpd_pkg::VALUE_W-1:0] rv;
        logic                                lok;
        logic                                rok;

        if (i == 0)
        begin : g_first
            assign lv  = item.value;
            assign lok = 1'b1;
        end
        else
        begin : g_mid_l
            assign lv  = cell_value[i-1];
            assign lok = cell_valid[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign rv  = '0;
            assign rok = 1'b0;
        end
        else
        begin : g_mid_r
            assign rv  = cell_value[i+1];
            assign rok = cell_valid[i+1];
        end

        bdpd_cell #(
            .INDEX (i)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctl         (ctl),
            .left_value  (lv),
            .left_valid  (lok),
            .right_value (rv),
            .right_valid (rok),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .last        (cell_last[i])
        );
    end

    // back word from the one cell flagged last, zero when empty
    always_comb
    begin
        back_word = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            back_word = back_word | (cell_last[i] ? cell_value[i] : '0);
        end
    end

    // result word
    assign busy               = 1'b0;
    assign result.status      = status;
    assign result.count       = bdpd_pkg::COUNT_W'(count);
    assign result.front_value = cell_valid[0] ? cell_value[0] : '0;
    assign result.back_value  = back_word;

    // occupancy never passes the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count <= COUNT_W'(DEPTH))
        else $error("occupancy above depth");

    // at most one cell is flagged last, so occupied cells form one run
    a_one_last: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_last))
        else $error("more than one last cell");

    // cell flags agree with the count
    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(cell_valid) == count)
        else $error("cell flags disagree with count");

    // a result word only follows a taken command
    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result without command");

endmodule

`default_nettype wire

/* tb/sv/bdpd_checker.sv */
`timescale 1ns / 100ps

module bdpd_checker
    import bdpd_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      start,
    input  wire logic      busy,
    input  wire in_word_t  item,
    input  wire logic      done,
    input  wire out_word_t result,
    output int             pending,
    output int             fail_count,
    output int             result_total,
    output int             full_total,
    output int             empty_total,
    output int             ignored_total,
    output int             peak_fill
);

    // shadow copy of the store, front at slot 0
    logic signed [VALUE_W-1:0] stored [DEPTH];
    int                        fill;
    out_word_t                 owed_words [$];

    // close the gap left by the entry at idx
    function automatic void drop_entry(input int idx);
        for (int i = idx; i < fill - 1; i++)
            stored[i] = stored[i + 1];
        fill--;
    endfunction

    // update the shadow store for one command word and build its result word
    function automatic out_word_t apply_command(input in_word_t w);
        out_word_t r;
        int        slot;
        r.status = ST_DONE;
        case (w.command)
            CMD_PUSH_FRONT:
                if (fill >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = fill; i > 0; i--)
                        stored[i] = stored[i - 1];
                    stored[0] = w.value;
                    fill++;
                end
            CMD_POP_FRONT:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                    drop_entry(0);
            CMD_POP_BACK:
                if (fill == 0)
                    r.status = ST_EMPTY;
                else
                    drop_entry(fill - 1);
            CMD_DELETE_AT:
            begin
                // position zero acts as the first entry
                slot = (w.position == '0) ? 1 : int'(w.position);
                if (fill == 0)
                    r.status = ST_EMPTY;
                else if (w.position[POS_W-1])
                    r.status = ST_IGNORED;
                else if (slot > fill)
                    r.status = ST_IGNORED;
                else
                    drop_entry(slot - 1);
            end
        endcase
        r.count       = COUNT_W'(fill);
        r.front_value = (fill > 0) ? stored[0] : '0;
        r.back_value  = (fill > 0) ? stored[fill - 1] : '0;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: result word %0d, %s: got %0h, expected %0h",
                 $realtime, result_total, what, got, want);
        fail_count++;
    endtask

    // field by field compare against the oldest owed word
    task automatic compare_word(input out_word_t want, input out_word_t got);
        if (got.status !== want.status)
            report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.count !== want.count)
            report_mismatch("count", 32'(got.count), 32'(want.count));
        if (got.front_value !== want.front_value)
            report_mismatch("front_value", got.front_value, want.front_value);
        if (got.back_value !== want.back_value)
            report_mismatch("back_value", got.back_value, want.back_value);
        case (want.status)
            ST_FULL:    full_total++;
            ST_EMPTY:   empty_total++;
            ST_IGNORED: ignored_total++;
            default:    ;
        endcase
        result_total++;
    endtask

    // results first, so a word taken on the same edge is never matched early
    always @(posedge clk or negedge rst_n)
    begin : watch
        out_word_t want;
        if (!rst_n)
        begin
            owed_words.delete();
            fill = 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (owed_words.size() == 0)
                    report_mismatch("result with nothing owed", result[31:0], '0);
                else
                begin
                    want = owed_words.pop_front();
                    compare_word(want, result);
                end
            end
            if (start && !busy)
            begin
                owed_words.push_back(apply_command(item));
                if (fill > peak_fill)
                    peak_fill = fill;
            end
            pending <= owed_words.size();
        end
    end

endmodule

/* tb/sv/tb_bounded_deque_positional_delete_core.sv */
`timescale 1ns / 100ps

module tb_bounded_deque_positional_delete_core;
    import bdpd_pkg::*;

    localparam int DEPTH        = 64;
    localparam int RANDOM_WORDS = 1750;
    localparam int DRAIN_LIMIT  = 1000;

    // command mix of one random burst
    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } mix_t;

    logic      clk   = 1'b0;
    logic      rst_n = 1'b0;
    logic      start = 1'b0;
    in_word_t  item  = '0;
    logic      busy;
    logic      done;
    out_word_t result;

    int pending;
    int fail_count;
    int result_total;
    int full_total;
    int empty_total;
    int ignored_total;
    int peak_fill;
    int est_fill   = 0;
    int words_sent = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    bounded_deque_positional_delete_core #(
        .DEPTH (DEPTH)
    ) u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .item   (item),
        .busy   (busy),
        .done   (done),
        .result (result)
    );

    bdpd_checker #(
        .DEPTH (DEPTH)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .item          (item),
        .done          (done),
        .result        (result),
        .pending       (pending),
        .fail_count    (fail_count),
        .result_total  (result_total),
        .full_total    (full_total),
        .empty_total   (empty_total),
        .ignored_total (ignored_total),
        .peak_fill     (peak_fill)
    );

    // run limit
    initial
    begin
        #3_000_000;
        $display("timeout with %0d result words owed", pending);
        $display("Test completed with failures");
        $finish;
    end

    // offer one command word and hold it until taken; track fill for stimulus shaping
    task automatic send_word(input cmd_t c, input logic signed [VALUE_W-1:0] v,
                             input logic signed [POS_W-1:0] p);
        in_word_t w;
        int       slot;
        w.command  = c;
        w.value    = v;
        w.position = p;
        start <= 1'b1;
        item  <= w;
        do
            @(posedge clk);
        while (busy);
        slot = (p == '0) ? 1 : int'(p);
        case (c)
            CMD_PUSH_FRONT: if (est_fill < DEPTH) est_fill++;
            CMD_POP_FRONT,
            CMD_POP_BACK:   if (est_fill > 0) est_fill--;
            CMD_DELETE_AT:  if (est_fill > 0 && p >= 0 && slot <= est_fill) est_fill--;
        endcase
        words_sent++;
    endtask

    // random idle cycles with junk on the word bus, none when quiet
    task automatic idle_gap(input bit quiet);
        logic [63:0] noise;
        if (!quiet)
            while ($urandom_range(99) < 26)
            begin
                noise = {$urandom, $urandom};
                start <= 1'b0;
                item  <= noise[$bits(in_word_t)-1:0];
                @(posedge clk);
            end
    endtask

    // hold off until every owed result word has come or the drain limit runs out
    task automatic drain_results();
        int waited;
        waited = 0;
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
    endtask

    function automatic logic signed [VALUE_W-1:0] pick_value();
        case ($urandom_range(19))
            0:       return 32'sh7fff_ffff;
            1:       return 32'sh8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // mostly valid slots, with first, last, beyond count and negative mixed in
    function automatic logic signed [POS_W-1:0] pick_position();
        int r;
        r = $urandom_range(99);
        if (est_fill == 0 || r >= 90)
            return POS_W'($urandom);
        if (r < 10)
            return '0;
        if (r < 20)
            return POS_W'(est_fill);
        if (r < 25)
            return POS_W'(1);
        if (r < 70)
            return POS_W'($urandom_range(est_fill, 1));
        if (r < 80)
            return POS_W'($urandom_range(32767, est_fill + 1));
        return {1'b1, 15'($urandom)};
    endfunction

    function automatic cmd_t pick_command(input mix_t mode);
        int push_share;
        push_share = (mode == MODE_FILL) ? 75 : (mode == MODE_DRAIN) ? 20 : 50;
        if ($urandom_range(99) < push_share)
            return CMD_PUSH_FRONT;
        case ($urandom_range(3))
            0:       return CMD_POP_FRONT;
            1:       return CMD_POP_BACK;
            default: return CMD_DELETE_AT;
        endcase
    endfunction

    initial
    begin : stimulus
        int   n;
        int   burst_left;
        mix_t mode;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store: every removal reports empty, even with a bad position
        send_word(CMD_POP_FRONT, pick_value(), 16'sd0);
        send_word(CMD_POP_BACK, pick_value(), 16'sd0);
        send_word(CMD_DELETE_AT, pick_value(), -16'sd1);
        send_word(CMD_DELETE_AT, pick_value(), 16'sd5);

        // value extremes
        send_word(CMD_PUSH_FRONT, 32'sh7fff_ffff, 16'sd0);
        send_word(CMD_PUSH_FRONT, 32'sh8000_0000, 16'sd0);
        send_word(CMD_PUSH_FRONT, 32'sd0, 16'sd0);
        send_word(CMD_PUSH_FRONT, -32'sd1, 16'sd0);

        // ignored positions: most negative, most positive, one past count
        send_word(CMD_DELETE_AT, pick_value(), 16'sh8000);
        send_word(CMD_DELETE_AT, pick_value(), 16'sh7fff);
        send_word(CMD_DELETE_AT, pick_value(), 16'sd5);

        // last entry moves the back, position zero takes the front, then a middle one
        send_word(CMD_DELETE_AT, pick_value(), 16'sd4);
        send_word(CMD_PUSH_FRONT, 32'sd12345, 16'sd0);
        send_word(CMD_DELETE_AT, pick_value(), 16'sd0);
        send_word(CMD_DELETE_AT, pick_value(), 16'sd2);
        send_word(CMD_PUSH_FRONT, 32'sh5a5a_5a5a, 16'sd0);
        send_word(CMD_POP_BACK, pick_value(), 16'sd0);
        send_word(CMD_POP_FRONT, pick_value(), 16'sd0);
        send_word(CMD_DELETE_AT, pick_value(), 16'sd1);
        send_word(CMD_POP_BACK, pick_value(), 16'sd0);
        drain_results();

        // fill to capacity, push into a full store, then delete at the far end
        while (est_fill < DEPTH)
        begin
            idle_gap(1'b0);
            send_word(CMD_PUSH_FRONT, pick_value(), POS_W'($urandom));
        end
        repeat (2) send_word(CMD_PUSH_FRONT, pick_value(), POS_W'($urandom));
        send_word(CMD_DELETE_AT, pick_value(), POS_W'(DEPTH));
        send_word(CMD_DELETE_AT, pick_value(), POS_W'(DEPTH));
        drain_results();

        // random bursts that swing the fill between empty and full
        burst_left = 0;
        mode       = MODE_MIX;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(120, 30);
                mode       = mix_t'($urandom_range(2));
            end
            burst_left--;
            if (n % 400 == 399)
                drain_results();
            idle_gap(n >= 700 && n < 1000);
            send_word(pick_command(mode), pick_value(), pick_position());
        end

        drain_results();
        repeat (4) @(posedge clk);

        $display("%0d command words sent, %0d result words checked, peak fill %0d of %0d",
                 words_sent, result_total, peak_fill, DEPTH);
        $display("pushes into a full store %0d, removals on an empty store %0d, %s %0d",
                 full_total, empty_total, "ignored positions", ignored_total);
        if (pending != 0)
            $display("%0d result words never arrived", pending);
        if (fail_count == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* bounded_deque_positional_delete_core.f */
sv/bdpd_pkg.sv
sv/bdpd_cell.sv
sv/bdpd_ctrl.sv
sv/bounded_deque_positional_delete_core.sv
tb/sv/bdpd_checker.sv
tb/sv/tb_bounded_deque_positional_delete_core.sv
